@@ rtl/jcrp_pkg.sv @@
package jcrp_pkg;

    localparam int PENDING_DEPTH_DEF = 16;
    localparam int JOURNAL_BYTES_DEF = 65536;
    localparam int BLOCK_BYTES_DEF   = 4096;

    localparam int USED_W      = 17;
    localparam int OFFS_W      = 17;
    localparam int CNT_MAX_W   = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DRN_W       = $clog2(QUEUE_DEPTH + 2);
    localparam int ENTRY_W     = 48;

    localparam logic [15:0]       TYPE_DATA    = 16'd1;
    localparam logic [15:0]       TYPE_COMMIT  = 16'd2;
    localparam logic [OFFS_W-1:0] HDR_BYTES    = 17'd4;
    localparam logic [OFFS_W-1:0] START_OFFSET = 17'd8;
    localparam logic [OFFS_W-1:0] IMAGE_SKIP   = 17'd8;

    typedef enum logic [3:0] {
        ST_BUFFERED   = 4'd0,
        ST_COMMITTED  = 4'd1,
        ST_RESTARTED  = 4'd2,
        ST_END        = 4'd3,
        ST_SMALL      = 4'd4,
        ST_PAST_END   = 4'd5,
        ST_BAD_DATA   = 4'd6,
        ST_BAD_COMMIT = 4'd7,
        ST_UNKNOWN    = 4'd8,
        ST_STOPPED    = 4'd9,
        ST_FULL       = 4'd10
    } t_status;

    typedef enum logic {
        B_IDLE,
        B_DRAIN
    } t_back_state;

    typedef struct packed {
        logic        func;
        logic [15:0] rec_type;
        logic [15:0] rec_size;
        logic [31:0] home_block;
    } t_in;

    typedef struct packed {
        logic        is_write;
        logic [31:0] dest_block;
        logic [15:0] image_offset;
        t_status     status;
        logic        last;
    } t_out;

    // one queued job for the back end: a single status result or a commit drain
    typedef struct packed {
        logic                 drain;
        t_status              status;
        logic [CNT_MAX_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

@@ rtl/jcrp_ram.sv @@
module jcrp_ram import jcrp_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = PENDING_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/jcrp_front.sv @@
module jcrp_front import jcrp_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int JOURNAL_BYTES = JOURNAL_BYTES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    input  logic [USED_W-1:0]  i_used,
    input  logic               i_q_full,
    input  logic               i_drain_done,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic               o_wr_en,
    output logic [IDX_W-1:0]   o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data
);

    localparam logic [20:0]       JB_LIMIT  = 21'(JOURNAL_BYTES);
    localparam logic [OFFS_W-1:0] DATA_SIZE = OFFS_W'(BLOCK_BYTES + 8);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(PENDING_DEPTH);

    logic [OFFS_W-1:0] r_off, n_off;
    logic              r_stopped, n_stopped;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DRN_W-1:0]  r_drains, n_drains;

    logic              accept;
    logic [USED_W-1:0] used;
    logic [OFFS_W:0]   off_hdr;
    logic [OFFS_W:0]   off_end;
    logic [OFFS_W-1:0] size_x;
    logic [OFFS_W-1:0] img_off;

    assign size_x  = {1'b0, i_in_data.rec_size};
    assign used    = ({4'b0, i_used} > JB_LIMIT) ? JB_LIMIT[USED_W-1:0] : i_used;
    assign off_hdr = {1'b0, r_off} + {1'b0, HDR_BYTES};
    assign off_end = {1'b0, r_off} + {1'b0, size_x};
    assign img_off = r_off + IMAGE_SKIP;

    // data records wait while a commit still reads the pending store
    assign o_in_stall = i_q_full || ((r_drains != '0) && !i_in_data.func &&
                        (i_in_data.rec_type == TYPE_DATA));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_off        = r_off;
        n_stopped    = r_stopped;
        n_cnt        = r_cnt;
        o_cmd.drain  = 1'b0;
        o_cmd.status = ST_STOPPED;
        o_cmd.count  = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_cnt[IDX_W-1:0];
        o_wr_data    = {i_in_data.home_block, img_off[15:0]};
        if (i_in_data.func) begin
            n_off        = START_OFFSET;
            n_stopped    = 1'b0;
            n_cnt        = '0;
            o_cmd.status = ST_RESTARTED;
        end else if (r_stopped) begin
            o_cmd.status = ST_STOPPED;
        end else begin
            n_stopped = 1'b1;
            n_cnt     = '0;
            if (off_hdr > {1'b0, used}) begin
                o_cmd.status = ST_END;
            end else if (size_x < HDR_BYTES) begin
                o_cmd.status = ST_SMALL;
            end else if (off_end > {1'b0, used}) begin
                o_cmd.status = ST_PAST_END;
            end else if (i_in_data.rec_type == TYPE_DATA) begin
                if (size_x != DATA_SIZE) begin
                    o_cmd.status = ST_BAD_DATA;
                end else if (r_cnt >= DEPTH_CNT) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    n_stopped    = 1'b0;
                    n_cnt        = r_cnt + 1'b1;
                    n_off        = off_end[OFFS_W-1:0];
                    o_wr_en      = accept;
                    o_cmd.status = ST_BUFFERED;
                end
            end else if (i_in_data.rec_type == TYPE_COMMIT) begin
                if (size_x != HDR_BYTES) begin
                    o_cmd.status = ST_BAD_COMMIT;
                end else begin
                    n_stopped    = 1'b0;
                    n_off        = off_end[OFFS_W-1:0];
                    o_cmd.status = ST_COMMITTED;
                    o_cmd.drain  = (r_cnt != '0);
                    o_cmd.count  = CNT_MAX_W'(r_cnt);
                end
            end else begin
                o_cmd.status = ST_UNKNOWN;
            end
        end
    end

    assign o_push = accept;

    always_comb begin
        n_drains = r_drains;
        if (accept && o_cmd.drain && !i_drain_done) begin
            n_drains = r_drains + 1'b1;
        end else if (!(accept && o_cmd.drain) && i_drain_done) begin
            n_drains = r_drains - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= START_OFFSET;
            r_stopped <= 1'b0;
            r_cnt     <= '0;
            r_drains  <= '0;
        end else begin
            r_drains <= n_drains;
            if (accept) begin
                r_off     <= n_off;
                r_stopped <= n_stopped;
                r_cnt     <= n_cnt;
            end
        end
    end

endmodule

@@ rtl/jcrp_queue.sv @@
module jcrp_queue import jcrp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/jcrp_back.sv @@
module jcrp_back import jcrp_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_head            i_head,
    output logic               o_pop,
    output logic               o_rd_en,
    output logic [IDX_W-1:0]   o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data,
    output logic               o_drain_done,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data
);

    t_back_state      r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_num, n_num;
    logic             r_out_valid;
    t_out             r_out;
    logic             load;
    t_out             load_data;
    logic             out_free;
    logic             is_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = ((CNT_W + 1)'(r_idx) + 1'b1) == (CNT_W + 1)'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_num        = r_num;
        o_pop        = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_drain_done = 1'b0;
        load         = 1'b0;
        load_data    = '{is_write: 1'b0, dest_block: '0, image_offset: '0,
                         status: i_head.cmd.status, last: 1'b1};
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.cmd.drain) begin
                        // first entry read now, data is there next cycle
                        o_rd_en = 1'b1;
                        n_idx   = '0;
                        n_num   = i_head.cmd.count[CNT_W-1:0];
                        n_state = B_DRAIN;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            B_DRAIN: begin
                load_data = '{is_write: 1'b1, dest_block: i_rd_data[47:16],
                              image_offset: i_rd_data[15:0], status: ST_COMMITTED,
                              last: is_last};
                if (out_free) begin
                    load = 1'b1;
                    if (is_last) begin
                        o_drain_done = 1'b1;
                        n_state      = B_IDLE;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_num <= n_num;
        if (load) begin
            r_out <= load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/journal_commit_replay_parser.sv @@
// journal redo scanner: takes record headers in journal order and turns
// committed data records into replay writes for their home blocks.
// input channel: i_in_valid / o_in_stall with a t_in request (func, type,
// size, home block); a func bit of one restarts the scan at offset 8.
// output channel: o_out_valid / i_out_stall with t_out results; every request
// gives one result with last set, except a commit over a pending list, which
// gives one write per pending entry in arrival order, last on the final one.
// a single result passes the job queue and the output register; the first write
// of a commit also waits on the pending store read, then one write per cycle while results are taken.
// throughput: a request per cycle while results are taken; a commit holds the
// result side while it reads its entries through the one read port of the
// pending store, and data records are held off until that commit has read it.
// a four-deep job queue between classifier and result side absorbs the rest.
// reset (synchronous, active low) sets the offset to 8, clears the stop flag,
// the pending list, the job queue and the used length (back to 8).
// a stalled result holds in the output register; the classifier runs on until
// the job queue fills, then stalls the input side.
// config: one apb register at address 0, journal_used_bytes; the user must write
// it only while the block is idle, which the block itself does not enforce.
module journal_commit_replay_parser import jcrp_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int JOURNAL_BYTES = JOURNAL_BYTES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [USED_W-1:0]  r_used;
    logic               q_full;
    logic               push;
    t_cmd               push_cmd;
    t_q_head            head;
    logic               pop;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               drain_done;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - USED_W){1'b0}}, r_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= START_OFFSET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_used <= pwdata[USED_W-1:0];
        end
    end

    jcrp_front #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .JOURNAL_BYTES (JOURNAL_BYTES),
        .BLOCK_BYTES   (BLOCK_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_used       (r_used),
        .i_q_full     (q_full),
        .i_drain_done (drain_done),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    jcrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    jcrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pending (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    jcrp_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_drain_done (drain_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule
